// ===== hw/rtl/rapal_pkg.sv =====
// rapal_pkg: shared types and constants for the reverse-and-add palindrome search
// no dependencies
package rapal_pkg;
    localparam int DATA_W = 64;
    localparam int STEP_W = 8;
    localparam int DIGITS = 20;
    localparam int DIG_IDX_W = 5;
    localparam int DIG_CNT_W = 5;
    localparam int MAX_STEPS_DEF = 255;

    typedef logic [3:0] t_digit;
endpackage

// ===== hw/rtl/rapal_front.sv =====
// rapal_front: input register stage and two-entry queue of start values
// depends on rapal_pkg
module rapal_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [rapal_pkg::DATA_W-1:0] i_start_value,
    output logic                       o_q_valid,
    input  logic                       i_q_take,
    output logic [rapal_pkg::DATA_W-1:0] o_q_value
);
    import rapal_pkg::*;

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wp, n_wp, r_rp, n_rp;
    logic [1:0]        r_cnt, n_cnt;
    logic              w_push, w_pop;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign w_pop     = i_q_take && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_value = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ w_pop;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_start_value;
        end
    end
endmodule

// ===== hw/rtl/rapal_back.sv =====
// rapal_back: digit-serial reverse-and-add engine with output register
// depends on rapal_pkg
module rapal_back #(
    parameter int MAX_STEPS = rapal_pkg::MAX_STEPS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_q_take,
    input  logic [rapal_pkg::DATA_W-1:0] i_q_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_found,
    output logic [rapal_pkg::DATA_W-1:0] o_palindrome_value,
    output logic [rapal_pkg::STEP_W-1:0] o_step_count
);
    import rapal_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CONV = 6'b000010,
        S_PAL  = 6'b000100,
        S_REV  = 6'b001000,
        S_ADD  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    // phases of the divide by ten; each pass through them yields one digit
    localparam logic [1:0] PH_T1  = 2'd0;
    localparam logic [1:0] PH_T3  = 2'd1;
    localparam logic [1:0] PH_Q   = 2'd2;
    localparam logic [1:0] PH_DIG = 2'd3;

    t_state            r_state, n_state;
    logic [DATA_W-1:0] r_sum, r_work, r_rev;
    t_digit            r_dig [DIGITS];
    logic [DIG_CNT_W-1:0] r_n, r_a, r_b;
    logic [STEP_W-1:0] r_steps;
    logic              r_found;
    logic              r_ov_valid;
    logic [1:0]        r_ph;
    logic [DATA_W-1:0] r_q;

    // divide by ten: shift-and-add approximation of 0.8*x, then /8 and one fixup
    logic [DATA_W-1:0] w_t0, w_t1, w_t2, w_t3, w_t4;
    logic [DATA_W-1:0] w_quo;
    logic [4:0]        w_q10;
    logic [4:0]        w_r;
    logic              w_fix;
    t_digit            w_dig;
    logic [DATA_W+4:0] w_rev10;
    logic [DATA_W:0]   w_add;
    logic              w_out_free;

    assign w_t0  = {1'b0, r_work[DATA_W-1:1]} + {2'b00, r_work[DATA_W-1:2]};
    assign w_t1  = w_t0 + {4'h0, w_t0[DATA_W-1:4]};
    assign w_t2  = r_q + {8'h00, r_q[DATA_W-1:8]};
    assign w_t3  = w_t2 + {16'h0000, w_t2[DATA_W-1:16]};
    assign w_t4  = r_q + {32'h0000_0000, r_q[DATA_W-1:32]};
    // low bits of quotient*10; remainder is below 20
    assign w_q10 = {r_q[1:0], 3'b000} + {r_q[3:0], 1'b0};
    assign w_r   = r_work[4:0] - w_q10;
    assign w_fix = (w_r > 5'd9);
    assign w_dig = w_fix ? 4'(w_r - 5'd10) : w_r[3:0];
    assign w_quo = r_q + {{(DATA_W-1){1'b0}}, w_fix};
    assign w_rev10 = {r_rev, 3'b000} + {2'b00, r_rev, 1'b0}
                   + {{(DATA_W+1){1'b0}}, r_dig[r_a[DIG_IDX_W-1:0]]};
    assign w_add  = {1'b0, r_sum} + {1'b0, r_rev};
    assign w_out_free = !r_ov_valid || !i_stall;
    assign o_q_take   = (r_state == S_IDLE) && i_q_valid;

    assign o_valid = r_ov_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ov_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) r_state <= S_CONV;
                end
                S_CONV: begin
                    if (r_work == '0) r_state <= S_PAL;
                end
                S_PAL: begin
                    if (r_a >= r_b) begin
                        r_state <= S_OUT;
                    end else if (r_dig[r_a[DIG_IDX_W-1:0]] !=
                                 r_dig[r_b[DIG_IDX_W-1:0]]) begin
                        r_state <= (r_steps == STEP_W'(MAX_STEPS)) ? S_OUT : S_REV;
                    end
                end
                S_REV: begin
                    if (r_a == r_n) r_state <= S_ADD;
                    else if (w_rev10[DATA_W+4:DATA_W] != '0) r_state <= S_OUT;
                end
                S_ADD: begin
                    r_state <= w_add[DATA_W] ? S_OUT : S_CONV;
                end
                S_OUT: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_OUT && w_out_free) r_ov_valid <= 1'b1;
            else if (!i_stall) r_ov_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sum   <= i_q_value;
                r_work  <= i_q_value;
                r_n     <= '0;
                r_steps <= '0;
                r_found <= 1'b0;
                r_ph    <= PH_T1;
            end
            S_CONV: begin
                if (r_work != '0) begin
                    r_ph <= r_ph + 1'b1;
                    case (r_ph)
                        PH_T1:  r_q <= w_t1;
                        PH_T3:  r_q <= w_t3;
                        PH_Q:   r_q <= {3'b000, w_t4[DATA_W-1:3]};
                        PH_DIG: begin
                            r_dig[r_n[DIG_IDX_W-1:0]] <= w_dig;
                            r_n    <= r_n + 1'b1;
                            r_work <= w_quo;
                        end
                        default: ;
                    endcase
                end else begin
                    r_a <= '0;
                    r_b <= (r_n == '0) ? '0 : r_n - 1'b1;
                end
            end
            S_PAL: begin
                if (r_a >= r_b) begin
                    r_found <= 1'b1;
                end else if (r_dig[r_a[DIG_IDX_W-1:0]] != r_dig[r_b[DIG_IDX_W-1:0]]) begin
                    r_a   <= '0;
                    r_rev <= '0;
                end else begin
                    r_a <= r_a + 1'b1;
                    r_b <= r_b - 1'b1;
                end
            end
            S_REV: begin
                if (r_a != r_n) begin
                    r_rev <= w_rev10[DATA_W-1:0];
                    r_a   <= r_a + 1'b1;
                end
            end
            S_ADD: begin
                if (!w_add[DATA_W]) begin
                    r_sum   <= w_add[DATA_W-1:0];
                    r_work  <= w_add[DATA_W-1:0];
                    r_n     <= '0;
                    r_steps <= r_steps + 1'b1;
                end
            end
            default: ;
        endcase
        if (r_state == S_OUT && w_out_free) begin
            o_found            <= r_found;
            o_palindrome_value <= r_found ? r_sum : '0;
            o_step_count       <= r_steps;
        end
    end
endmodule

// ===== hw/rtl/reverse_add_palindrome_search_core.sv =====
// reverse_add_palindrome_search_core: top level, front queue plus search engine
// depends on rapal_pkg, rapal_front, rapal_back
// Each start value is queued (two entries) and worked by a single engine, one value
// at a time. Per step the sum is split into decimal digits (shift-and-add divide by
// ten), checked for palindrome one digit pair per cycle, reversed one digit per cycle
// with an exact overflow test and then added. Up to MAX_STEPS steps (255 by default)
// are taken, though 64-bit overflow ends real chains after a few dozen steps; the
// digit loop of the engine sets the rate. One result per item comes out in order
// through a registered output; a stalled result holds the engine, and the queue
// raises o_stall once two more start values wait.
module reverse_add_palindrome_search_core #(
    parameter int MAX_STEPS = rapal_pkg::MAX_STEPS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [rapal_pkg::DATA_W-1:0] i_start_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_found,
    output logic [rapal_pkg::DATA_W-1:0] o_palindrome_value,
    output logic [rapal_pkg::STEP_W-1:0] o_step_count
);
    import rapal_pkg::*;

    logic              w_q_valid, w_q_take;
    logic [DATA_W-1:0] w_q_value;

    // front: accept and buffer start values
    rapal_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_start_value,
        .o_q_valid(w_q_valid), .i_q_take(w_q_take), .o_q_value(w_q_value)
    );

    // back: search engine
    rapal_back #(.MAX_STEPS(MAX_STEPS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_q_valid), .o_q_take(w_q_take), .i_q_value(w_q_value),
        .o_valid, .i_stall, .o_found, .o_palindrome_value, .o_step_count
    );
endmodule

// ===== hw/rtl/rapal_checker.sv =====
// rapal_checker: port-level assertions for the search core
// depends on rapal_pkg, bound to reverse_add_palindrome_search_core
module rapal_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic                         o_found,
    input logic [rapal_pkg::DATA_W-1:0] o_palindrome_value,
    input logic [rapal_pkg::STEP_W-1:0] o_step_count
);
    import rapal_pkg::*;

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_palindrome_value == '0) else $error("value not zero");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_palindrome_value)
            && $stable(o_found) && $stable(o_step_count)) else $error("hold");
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall) else $error("stall after reset");
endmodule

bind reverse_add_palindrome_search_core rapal_checker u_rapal_checker (.*);

// ===== dv/reverse_add_palindrome_search_checker.sv =====
// reverse_add_palindrome_search_checker: watches both channels of the search core,
// predicts each result from the start value and compares in order
// depends on rapal_pkg
module reverse_add_palindrome_search_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_stall_up,
    input  logic [rapal_pkg::DATA_W-1:0] i_start_value,
    input  logic                         i_res_valid,
    input  logic                         i_res_stall,
    input  logic                         i_found,
    input  logic [rapal_pkg::DATA_W-1:0] i_palindrome_value,
    input  logic [rapal_pkg::STEP_W-1:0] i_step_count,
    output int                           o_req_count,
    output int                           o_res_count,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ALL_ONES = '1;

    typedef struct packed {
        logic                         found;
        logic [rapal_pkg::DATA_W-1:0] value;
        logic [rapal_pkg::STEP_W-1:0] steps;
    } t_search_result;

    t_search_result search_results_due[$];

    function automatic bit is_decimal_palindrome(logic [63:0] v);
        logic [3:0] dig[20];
        int         n;
        int         a;
        int         b;
        n = 0;
        while (v != 0) begin
            dig[n] = 4'(v % 10);
            v = v / 10;
            n++;
        end
        a = 0;
        b = n - 1;
        while (a < b) begin
            if (dig[a] != dig[b]) return 0;
            a++;
            b--;
        end
        return 1;
    endfunction

    // reversal of v, ok cleared if it does not fit in 64 bits
    function automatic logic [63:0] reverse_decimal(logic [63:0] v, output bit ok);
        logic [63:0] r;
        logic [63:0] d;
        r = 0;
        ok = 1;
        while (v != 0) begin
            d = v % 10;
            v = v / 10;
            if (r > (ALL_ONES - d) / 10) begin
                ok = 0;
                return 0;
            end
            r = r * 10 + d;
        end
        return r;
    endfunction

    function automatic t_search_result search_palindrome(logic [63:0] start);
        t_search_result res;
        logic [63:0]    sum;
        logic [63:0]    rev;
        bit             ok;
        int             steps;
        sum = start;
        steps = 0;
        res = '0;
        if (is_decimal_palindrome(sum)) begin
            res.found = 1;
            res.value = sum;
            return res;
        end
        while (steps < rapal_pkg::MAX_STEPS_DEF) begin
            rev = reverse_decimal(sum, ok);
            if (!ok) break;
            if (ALL_ONES - sum < rev) break;
            sum = sum + rev;
            steps++;
            if (is_decimal_palindrome(sum)) begin
                res.found = 1;
                res.value = sum;
                res.steps = 8'(steps);
                return res;
            end
        end
        res.steps = 8'(steps);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at result %0d: %s got %0d want %0d", o_res_count, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_req_count = 0;
        o_res_count = 0;
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_search_result want;
        if (i_rst_n) begin
            if (i_valid && !i_stall_up) begin
                search_results_due.push_back(search_palindrome(i_start_value));
                o_req_count <= o_req_count + 1;
            end
            if (i_res_valid && !i_res_stall) begin
                if (search_results_due.size() == 0) begin
                    report_mismatch("unexpected result, value", i_palindrome_value, '0);
                end else begin
                    want = search_results_due.pop_front();
                    if (i_found != want.found)
                        report_mismatch("found", 64'(i_found), 64'(want.found));
                    if (i_palindrome_value != want.value)
                        report_mismatch("palindrome_value", i_palindrome_value, want.value);
                    if (i_step_count != want.steps)
                        report_mismatch("step_count", 64'(i_step_count), 64'(want.steps));
                end
                o_res_count <= o_res_count + 1;
            end
            o_pending <= search_results_due.size();
        end
    end
endmodule

// ===== dv/tb_reverse_add_palindrome_search_core.sv =====
// tb_reverse_add_palindrome_search_core: stimulus and verdict for the search core
// depends on rapal_pkg, reverse_add_palindrome_search_core, reverse_add_palindrome_search_checker
module tb_reverse_add_palindrome_search_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_REQS = 850;
    // watchdog limit, covering the worst items plus gaps and stalls
    localparam longint CYCLE_LIMIT = 100_000_000;
    localparam logic [63:0] ALL_ONES = '1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_start_value;
    logic        o_valid;
    logic        i_stall;
    logic        o_found;
    logic [63:0] o_palindrome_value;
    logic [7:0]  o_step_count;

    int          req_count;
    int          res_count;
    int          fail_count;
    int          pending;
    longint      cycle_count;
    bit          calm_phase;    // no idling on either side while set
    int          reqs_sent;

    reverse_add_palindrome_search_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_start_value     (i_start_value),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_found           (o_found),
        .o_palindrome_value(o_palindrome_value),
        .o_step_count      (o_step_count)
    );

    // predicts and compares everything on both channels
    reverse_add_palindrome_search_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .i_stall_up        (o_stall),
        .i_start_value     (i_start_value),
        .i_res_valid       (o_valid),
        .i_res_stall       (i_stall),
        .i_found           (o_found),
        .i_palindrome_value(o_palindrome_value),
        .i_step_count      (o_step_count),
        .o_req_count       (req_count),
        .o_res_count       (res_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial i_clk = 0;
    always #6 i_clk = ~i_clk;

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: after each accepted result hold stall for a random number of cycles
    initial begin
        int seen;
        int hold;
        seen = 0;
        hold = 0;
        i_stall = 0;
        forever begin
            @(negedge i_clk);
            if (res_count != seen) begin
                seen = res_count;
                hold = calm_phase ? 0 : $urandom_range(0, 17);
            end
            if (hold > 0) begin
                i_stall <= 1;
                hold--;
            end else begin
                i_stall <= 0;
            end
        end
    end

    // random number with a random count of decimal digits (1..20, clipped to 64 bits)
    function automatic logic [63:0] random_digits(int ndig);
        logic [63:0] v;
        v = 0;
        for (int k = 0; k < ndig; k++) begin
            if (v > (ALL_ONES - 9) / 10) break;
            v = v * 10 + $urandom_range(0, 9);
        end
        return v;
    endfunction

    // decimal palindrome built by mirroring random digits, up to 19 digits
    function automatic logic [63:0] random_palindrome();
        logic [3:0]  half[10];
        int          ndig;
        logic [63:0] v;
        ndig = $urandom_range(1, 19);
        for (int k = 0; k < 10; k++) half[k] = 4'($urandom_range(0, 9));
        half[0] = 4'($urandom_range(1, 9));
        v = 0;
        for (int k = 0; k < ndig; k++)
            v = v * 10 + ((k < (ndig + 1) / 2) ? half[k] : half[ndig - 1 - k]);
        return v;
    endfunction

    // one request: optional gap with valid low, then hold until accepted
    task automatic send_start(logic [63:0] v);
        int gap;
        gap = calm_phase ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1;
        i_start_value <= v;
        reqs_sent++;
        do @(negedge i_clk); while (req_count != reqs_sent);
    endtask

    initial begin
        logic [63:0] v;
        int          pick;
        i_rst_n = 0;
        i_valid = 0;
        i_start_value = 0;
        calm_phase = 0;
        reqs_sent = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: zero, single digits, short and known long chains, overflow edges
        send_start(64'd0);
        send_start(64'd1);
        send_start(64'd9);
        send_start(64'd10);
        send_start(64'd11);
        send_start(64'd56);
        send_start(64'd89);
        send_start(64'd196);
        send_start(64'd10911);
        send_start(64'd1186060307891929990);
        send_start(64'd9999999999999999999);
        send_start(64'd10000000000000000000);
        send_start(64'd18446744073709551615);
        send_start(64'd18446744073709551614);
        send_start(64'h8000_0000_0000_0000);
        send_start(64'hAAAA_AAAA_AAAA_AAAA);
        send_start(64'h5555_5555_5555_5555);
        send_start(64'd1000000000000000001);
        send_start(64'd9223372036854775807);

        // random: mix of short numbers, full 64-bit words, palindromes and values near the top
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 100 == 0) calm_phase = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                v = random_digits($urandom_range(1, 12));
            else if (pick < 60)
                v = random_digits($urandom_range(13, 20));
            else if (pick < 80)
                v = {$urandom(), $urandom()};
            else if (pick < 92)
                v = random_palindrome();
            else
                v = ALL_ONES - 64'($urandom_range(0, 100000));
            send_start(v);
        end
        i_valid <= 0;
        calm_phase = 0;

        while (pending != 0 || res_count != reqs_sent) @(negedge i_clk);
        repeat (60) @(negedge i_clk);

        $display("ran %0d start values (directed edges plus random widths and palindromes)",
                 reqs_sent);
        $display("%0d results checked over %0d cycles with random gaps and stalls",
                 res_count, cycle_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
